[src/rms_pkg.sv]
// Shared types, codes and constants of the robot motion supervisor.
package rms_pkg;

  localparam int TIME_W     = 32;
  localparam int DIST_W     = 10;
  localparam int SPEED_W    = 10;
  localparam int WHEEL_W    = 8;
  localparam int ACT_W      = 2;
  localparam int AMT_W      = 15;
  localparam int CNT_W      = 4;
  localparam int ENTRY_W    = ACT_W + AMT_W;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam int QUEUE_SLOTS_DEF = 16;

  localparam logic [SPEED_W-1:0] AMOUNT_SCALE = 10'd1000;
  localparam int MUL_W     = AMT_W + SPEED_W;
  localparam int DIV_STEPS = MUL_W;
  localparam int DIVCNT_W  = $clog2(DIV_STEPS);

  localparam logic [TIME_W-1:0]  RST_HOST_TIMEOUT = 32'd1000;
  localparam logic [SPEED_W-1:0] RST_LINEAR_SPEED = 10'd20;
  localparam logic [SPEED_W-1:0] RST_ROT_RATE     = 10'd90;
  localparam logic [DIST_W-1:0]  RST_NEAR_CM      = 10'd20;
  localparam logic [DIST_W-1:0]  RST_CLEAR_CM     = 10'd40;
  localparam logic [WHEEL_W-1:0] RST_STRAIGHT_WHL = 8'd200;
  localparam logic [WHEEL_W-1:0] RST_TURN_WHL     = 8'd150;

  typedef enum logic [1:0] {
    RS_IDLE   = 2'd0,
    RS_MOVING = 2'd1,
    RS_EMERG  = 2'd2
  } robot_state_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_STOP = 2'd0,
    ACT_FWD  = 2'd1,
    ACT_BACK = 2'd2,
    ACT_TURN = 2'd3
  } action_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_HOST_TIMEOUT = 3'd0,
    CFG_LINEAR_SPEED = 3'd1,
    CFG_ROT_RATE     = 3'd2,
    CFG_NEAR_CM      = 3'd3,
    CFG_CLEAR_CM     = 3'd4,
    CFG_STRAIGHT_WHL = 3'd5,
    CFG_TURN_WHL     = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_ADD,
    S_FIN,
    S_DONE
  } seq_state_t;

  localparam logic [0:0] MODE_TICK = 1'b0;
  localparam logic [0:0] MODE_ENQ  = 1'b1;

endpackage

[src/rms_ifs.sv]
// Request and result channel interfaces of the robot motion supervisor.
interface rms_in_if;
  logic                        valid;
  logic                        ready;
  logic                        mode;
  logic [rms_pkg::TIME_W-1:0]  now_ms;
  logic [rms_pkg::DIST_W-1:0]  front_distance_cm;
  logic [rms_pkg::TIME_W-1:0]  last_host_msg_ms;
  logic [rms_pkg::ACT_W-1:0]   cmd_action;
  logic [rms_pkg::AMT_W-1:0]   cmd_amount;

  modport source (
    output valid, mode, now_ms, front_distance_cm, last_host_msg_ms, cmd_action, cmd_amount,
    input  ready
  );
  modport sink (
    input  valid, mode, now_ms, front_distance_cm, last_host_msg_ms, cmd_action, cmd_amount,
    output ready
  );
endinterface

interface rms_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  robot_state;
  logic [rms_pkg::TIME_W-1:0]  end_time_ms;
  logic [rms_pkg::ACT_W-1:0]   active_action;
  logic [rms_pkg::AMT_W-1:0]   active_amount;
  logic                        command_active;
  logic [rms_pkg::WHEEL_W-1:0] wheel_speed;
  logic [rms_pkg::CNT_W-1:0]   queue_count;
  logic                        queue_overflow;

  modport source (
    output valid, robot_state, end_time_ms, active_action, active_amount, command_active,
           wheel_speed, queue_count, queue_overflow,
    input  ready
  );
  modport sink (
    input  valid, robot_state, end_time_ms, active_action, active_amount, command_active,
           wheel_speed, queue_count, queue_overflow,
    output ready
  );
endinterface

[src/robot_motion_supervisor_unit.sv]
// Top level of the robot motion supervisor: command queue, sequencer and serial divider.
//
//   channel   dir  handshake          contents
//   in_chan   in   valid/ready        tick (time, distance, host time) or enqueue command
//   out_chan  out  valid/ready        state, end time, active command, wheel, queue level
//   cfg_*     in   cfg_we, no ready   register index and write data
//
// Enqueue goes to S_DONE; a tick passes S_CHECK, S_EVAL and, to start a move, S_MUL,
// S_DIV (a 25-step restoring divider, one quotient bit a cycle), S_ADD and S_FIN.
// Reset clears the sequencer, supervisor state, queue pointers and config registers;
// queue entries stay undefined until written and need no clearing pass.
// A finished result waits in the output register while a new request is taken; the
// sequencer holds its next result until that register is free.
module robot_motion_supervisor_unit #(
  parameter int QUEUE_SLOTS = rms_pkg::QUEUE_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rms_in_if.sink                          in_chan,
  rms_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [rms_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [rms_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PTR_W = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int LVL_W = PTR_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_SLOTS - 1);
  localparam logic [LVL_W-1:0] LVL_SLOTS = LVL_W'(QUEUE_SLOTS);

  // configuration
  logic [rms_pkg::TIME_W-1:0]  host_timeout_r;
  logic [rms_pkg::SPEED_W-1:0] linear_speed_r;
  logic [rms_pkg::SPEED_W-1:0] rot_rate_r;
  logic [rms_pkg::DIST_W-1:0]  near_cm_r;
  logic [rms_pkg::DIST_W-1:0]  clear_cm_r;
  logic [rms_pkg::WHEEL_W-1:0] straight_whl_r;
  logic [rms_pkg::WHEEL_W-1:0] turn_whl_r;

  // sequencer
  rms_pkg::seq_state_t st_r, st_nxt;

  // supervisor state
  rms_pkg::robot_state_t       rstate_r, rstate_nxt;
  logic [rms_pkg::TIME_W-1:0]  end_r, end_nxt;
  logic [rms_pkg::ACT_W-1:0]   cur_act_r, cur_act_nxt;
  logic [rms_pkg::AMT_W-1:0]   cur_amt_r, cur_amt_nxt;
  logic                        cur_vld_r, cur_vld_nxt;
  logic [rms_pkg::WHEEL_W-1:0] wheel_r, wheel_nxt;
  logic [PTR_W-1:0]            head_r, head_nxt;
  logic [PTR_W-1:0]            tail_r, tail_nxt;
  logic                        ovf_r, ovf_nxt;

  // captured request and work registers
  logic [rms_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic [rms_pkg::DIST_W-1:0]   dist_r, dist_nxt;
  logic [rms_pkg::TIME_W-1:0]   last_r, last_nxt;
  logic                         wd_r, wd_nxt;
  logic [rms_pkg::SPEED_W-1:0]  ratio_r, ratio_nxt;
  logic [rms_pkg::MUL_W-1:0]    dvd_r, dvd_nxt;
  logic [rms_pkg::SPEED_W-1:0]  rem_r, rem_nxt;
  logic [rms_pkg::DIVCNT_W-1:0] cnt_r, cnt_nxt;

  // queue memory
  logic [rms_pkg::ENTRY_W-1:0] mem [QUEUE_SLOTS];
  logic [rms_pkg::ENTRY_W-1:0] rd_r;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [1:0]                  o_state_r, o_state_nxt;
  logic [rms_pkg::TIME_W-1:0]  o_end_r, o_end_nxt;
  logic [rms_pkg::ACT_W-1:0]   o_act_r, o_act_nxt;
  logic [rms_pkg::AMT_W-1:0]   o_amt_r, o_amt_nxt;
  logic                        o_vld_r, o_vld_nxt;
  logic [rms_pkg::WHEEL_W-1:0] o_whl_r, o_whl_nxt;
  logic [rms_pkg::CNT_W-1:0]   o_cnt_r, o_cnt_nxt;
  logic                        o_ovf_r, o_ovf_nxt;

  // decisions
  logic                        in_fire, out_fire, out_free;
  logic                        full_w, empty_w, near_w, clear_w, cancel_w, start_div_w;
  logic                        end_due_w;
  logic [PTR_W-1:0]            tail_next_w, head_next_w;
  logic [LVL_W-1:0]            level_w;
  logic [rms_pkg::ACT_W-1:0]   peek_act_w;
  logic [rms_pkg::TIME_W-1:0]  silence_w;
  logic [rms_pkg::SPEED_W-1:0] ratio_sel_w;
  logic [rms_pkg::SPEED_W+1:0] diff_w;
  logic [rms_pkg::SPEED_W:0]   shifted_w;
  rms_pkg::robot_state_t       st1_w;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_valid_r && out_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready = (st_r == rms_pkg::S_IDLE);

  assign tail_next_w = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
  assign head_next_w = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign full_w      = (tail_next_w == head_r);
  assign empty_w     = (head_r == tail_r);
  assign level_w     = {1'b0, tail_r} - {1'b0, head_r} + ((tail_r < head_r) ? LVL_SLOTS : '0);

  assign peek_act_w  = rd_r[rms_pkg::ENTRY_W-1:rms_pkg::AMT_W];
  assign near_w      = (dist_r <= near_cm_r);
  assign clear_w     = (dist_r > clear_cm_r);
  assign silence_w   = now_r - last_r;
  assign st1_w       = (rstate_r == rms_pkg::RS_MOVING && wd_r) ? rms_pkg::RS_IDLE : rstate_r;
  assign cancel_w    = (st1_w == rms_pkg::RS_MOVING) && !empty_w &&
                       (peek_act_w == rms_pkg::ACT_STOP);
  assign start_div_w = !near_w && (rstate_r != rms_pkg::RS_EMERG) &&
                       (st1_w == rms_pkg::RS_IDLE) && !empty_w &&
                       (peek_act_w != rms_pkg::ACT_STOP);
  assign end_due_w   = (now_r >= end_r);
  assign ratio_sel_w = (peek_act_w == rms_pkg::ACT_FWD || peek_act_w == rms_pkg::ACT_BACK) ?
                       linear_speed_r : rot_rate_r;

  assign shifted_w = {rem_r, dvd_r[rms_pkg::MUL_W-1]};
  assign diff_w    = {1'b0, shifted_w} - {2'b00, ratio_r};

  // sequencer next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      rms_pkg::S_IDLE: begin
        if (in_fire) begin
          st_nxt = (in_chan.mode == rms_pkg::MODE_ENQ) ? rms_pkg::S_DONE : rms_pkg::S_CHECK;
        end
      end
      rms_pkg::S_CHECK: st_nxt = rms_pkg::S_EVAL;
      rms_pkg::S_EVAL:  st_nxt = start_div_w ? rms_pkg::S_MUL : rms_pkg::S_DONE;
      rms_pkg::S_MUL:   st_nxt = rms_pkg::S_DIV;
      rms_pkg::S_DIV: begin
        if (cnt_r == rms_pkg::DIVCNT_W'(rms_pkg::DIV_STEPS - 1)) begin
          st_nxt = rms_pkg::S_ADD;
        end
      end
      rms_pkg::S_ADD:   st_nxt = rms_pkg::S_FIN;
      rms_pkg::S_FIN:   st_nxt = rms_pkg::S_DONE;
      rms_pkg::S_DONE: begin
        if (out_free) begin
          st_nxt = rms_pkg::S_IDLE;
        end
      end
      default: st_nxt = rms_pkg::S_IDLE;
    endcase
  end

  // datapath and output register next values
  always_comb begin
    rstate_nxt  = rstate_r;
    end_nxt     = end_r;
    cur_act_nxt = cur_act_r;
    cur_amt_nxt = cur_amt_r;
    cur_vld_nxt = cur_vld_r;
    wheel_nxt   = wheel_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    ovf_nxt     = ovf_r;
    now_nxt     = now_r;
    dist_nxt    = dist_r;
    last_nxt    = last_r;
    wd_nxt      = wd_r;
    ratio_nxt   = ratio_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;

    out_valid_nxt = out_fire ? 1'b0 : out_valid_r;
    o_state_nxt   = o_state_r;
    o_end_nxt     = o_end_r;
    o_act_nxt     = o_act_r;
    o_amt_nxt     = o_amt_r;
    o_vld_nxt     = o_vld_r;
    o_whl_nxt     = o_whl_r;
    o_cnt_nxt     = o_cnt_r;
    o_ovf_nxt     = o_ovf_r;

    case (st_r)
      rms_pkg::S_IDLE: begin
        if (in_fire) begin
          now_nxt  = in_chan.now_ms;
          dist_nxt = in_chan.front_distance_cm;
          last_nxt = in_chan.last_host_msg_ms;
          if (in_chan.mode == rms_pkg::MODE_ENQ) begin
            ovf_nxt = full_w;
            if (!full_w) begin
              tail_nxt = tail_next_w;
            end
          end else begin
            ovf_nxt = 1'b0;
          end
        end
      end
      rms_pkg::S_CHECK: begin
        wd_nxt = (silence_w > host_timeout_r);
      end
      rms_pkg::S_EVAL: begin
        if (near_w) begin
          rstate_nxt = rms_pkg::RS_EMERG;
          end_nxt    = '0;
        end else if (rstate_r == rms_pkg::RS_EMERG) begin
          if (clear_w) begin
            rstate_nxt = rms_pkg::RS_IDLE;
          end
        end else if (cancel_w) begin
          head_nxt    = head_next_w;
          cur_act_nxt = rms_pkg::ACT_STOP;
          cur_amt_nxt = '0;
          cur_vld_nxt = 1'b0;
          rstate_nxt  = rms_pkg::RS_IDLE;
          end_nxt     = '0;
        end else if (st1_w == rms_pkg::RS_IDLE) begin
          rstate_nxt = rms_pkg::RS_IDLE;
          end_nxt    = '0;
          if (!empty_w) begin
            head_nxt    = head_next_w;
            cur_act_nxt = peek_act_w;
            cur_amt_nxt = rd_r[rms_pkg::AMT_W-1:0];
            cur_vld_nxt = 1'b1;
            if (peek_act_w != rms_pkg::ACT_STOP) begin
              wheel_nxt = (ratio_sel_w == linear_speed_r &&
                           (peek_act_w == rms_pkg::ACT_FWD || peek_act_w == rms_pkg::ACT_BACK))
                          ? straight_whl_r : turn_whl_r;
              ratio_nxt = (ratio_sel_w == '0) ? rms_pkg::SPEED_W'(1) : ratio_sel_w;
            end
          end
        end else if (end_due_w) begin
          rstate_nxt  = rms_pkg::RS_IDLE;
          end_nxt     = '0;
          cur_act_nxt = rms_pkg::ACT_STOP;
          cur_amt_nxt = '0;
          cur_vld_nxt = 1'b0;
        end
      end
      rms_pkg::S_MUL: begin
        dvd_nxt = rms_pkg::MUL_W'(cur_amt_r) * rms_pkg::MUL_W'(rms_pkg::AMOUNT_SCALE);
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      rms_pkg::S_DIV: begin
        if (!diff_w[rms_pkg::SPEED_W+1]) begin
          rem_nxt = diff_w[rms_pkg::SPEED_W-1:0];
        end else begin
          rem_nxt = shifted_w[rms_pkg::SPEED_W-1:0];
        end
        dvd_nxt = {dvd_r[rms_pkg::MUL_W-2:0], !diff_w[rms_pkg::SPEED_W+1]};
        cnt_nxt = cnt_r + rms_pkg::DIVCNT_W'(1);
      end
      rms_pkg::S_ADD: begin
        end_nxt    = now_r + rms_pkg::TIME_W'(dvd_r);
        rstate_nxt = rms_pkg::RS_MOVING;
      end
      rms_pkg::S_FIN: begin
        if (end_due_w) begin
          rstate_nxt  = rms_pkg::RS_IDLE;
          end_nxt     = '0;
          cur_act_nxt = rms_pkg::ACT_STOP;
          cur_amt_nxt = '0;
          cur_vld_nxt = 1'b0;
        end
      end
      rms_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_state_nxt   = rstate_r;
          o_end_nxt     = end_r;
          o_act_nxt     = cur_act_r;
          o_amt_nxt     = cur_amt_r;
          o_vld_nxt     = cur_vld_r;
          o_whl_nxt     = wheel_r;
          o_cnt_nxt     = rms_pkg::CNT_W'(level_w);
          o_ovf_nxt     = ovf_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rms_pkg::S_IDLE;
      rstate_r    <= rms_pkg::RS_IDLE;
      end_r       <= '0;
      cur_act_r   <= rms_pkg::ACT_STOP;
      cur_amt_r   <= '0;
      cur_vld_r   <= 1'b0;
      wheel_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rstate_r    <= rstate_nxt;
      end_r       <= end_nxt;
      cur_act_r   <= cur_act_nxt;
      cur_amt_r   <= cur_amt_nxt;
      cur_vld_r   <= cur_vld_nxt;
      wheel_r     <= wheel_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r     <= now_nxt;
    dist_r    <= dist_nxt;
    last_r    <= last_nxt;
    wd_r      <= wd_nxt;
    ratio_r   <= ratio_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    o_state_r <= o_state_nxt;
    o_end_r   <= o_end_nxt;
    o_act_r   <= o_act_nxt;
    o_amt_r   <= o_amt_nxt;
    o_vld_r   <= o_vld_nxt;
    o_whl_r   <= o_whl_nxt;
    o_cnt_r   <= o_cnt_nxt;
    o_ovf_r   <= o_ovf_nxt;
  end

  // queue memory: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (in_fire && in_chan.mode == rms_pkg::MODE_ENQ && !full_w) begin
      mem[tail_r] <= {in_chan.cmd_action, in_chan.cmd_amount};
    end
    rd_r <= mem[head_r];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_timeout_r <= rms_pkg::RST_HOST_TIMEOUT;
      linear_speed_r <= rms_pkg::RST_LINEAR_SPEED;
      rot_rate_r     <= rms_pkg::RST_ROT_RATE;
      near_cm_r      <= rms_pkg::RST_NEAR_CM;
      clear_cm_r     <= rms_pkg::RST_CLEAR_CM;
      straight_whl_r <= rms_pkg::RST_STRAIGHT_WHL;
      turn_whl_r     <= rms_pkg::RST_TURN_WHL;
    end else if (cfg_we) begin
      case (cfg_addr)
        rms_pkg::CFG_HOST_TIMEOUT: host_timeout_r <= cfg_wdata[rms_pkg::TIME_W-1:0];
        rms_pkg::CFG_LINEAR_SPEED: linear_speed_r <= cfg_wdata[rms_pkg::SPEED_W-1:0];
        rms_pkg::CFG_ROT_RATE:     rot_rate_r     <= cfg_wdata[rms_pkg::SPEED_W-1:0];
        rms_pkg::CFG_NEAR_CM:      near_cm_r      <= cfg_wdata[rms_pkg::DIST_W-1:0];
        rms_pkg::CFG_CLEAR_CM:     clear_cm_r     <= cfg_wdata[rms_pkg::DIST_W-1:0];
        rms_pkg::CFG_STRAIGHT_WHL: straight_whl_r <= cfg_wdata[rms_pkg::WHEEL_W-1:0];
        rms_pkg::CFG_TURN_WHL:     turn_whl_r     <= cfg_wdata[rms_pkg::WHEEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.robot_state    = o_state_r;
  assign out_chan.end_time_ms    = o_end_r;
  assign out_chan.active_action  = o_act_r;
  assign out_chan.active_amount  = o_amt_r;
  assign out_chan.command_active = o_vld_r;
  assign out_chan.wheel_speed    = o_whl_r;
  assign out_chan.queue_count    = o_cnt_r;
  assign out_chan.queue_overflow = o_ovf_r;

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> st_r != rms_pkg::S_IDLE)
    else $error("sequencer stayed idle after a request");

  a_moving_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    rstate_r == rms_pkg::RS_MOVING |-> cur_vld_r)
    else $error("moving without a held command");

  a_end_only_moving: assert property (@(posedge clk) disable iff (!rst_n)
    rstate_r != rms_pkg::RS_MOVING |-> end_r == '0)
    else $error("end time set while not moving");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == rms_pkg::S_DIV |=> (st_r == rms_pkg::S_DIV || st_r == rms_pkg::S_ADD))
    else $error("divider left early");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == rms_pkg::S_DONE && !out_free) |=> st_r == rms_pkg::S_DONE)
    else $error("result dropped while output register full");
`endif

endmodule

[tb/tb.sv]
// Testbench of robot_motion_supervisor_unit: directed and random requests checked by a scoreboard.
module tb;

  localparam int RING_SLOTS     = rms_pkg::QUEUE_SLOTS_DEF;
  localparam int MS_PER_S       = 1000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int STALL_LIMIT    = 3000;
  localparam int SQUEEZE_CYCLES = 400;
  localparam int IDLE_PCT       = 19;
  localparam int REPORT_CAP     = 40;

  typedef struct {
    logic [rms_pkg::TIME_W-1:0]  host_timeout;
    logic [rms_pkg::SPEED_W-1:0] linear_speed;
    logic [rms_pkg::SPEED_W-1:0] rot_rate;
    logic [rms_pkg::DIST_W-1:0]  near_cm;
    logic [rms_pkg::DIST_W-1:0]  clear_cm;
    logic [rms_pkg::WHEEL_W-1:0] straight_whl;
    logic [rms_pkg::WHEEL_W-1:0] turn_whl;
  } sup_cfg_t;

  typedef struct {
    logic                       mode;
    logic [rms_pkg::TIME_W-1:0] now_ms;
    logic [rms_pkg::DIST_W-1:0] dist_cm;
    logic [rms_pkg::TIME_W-1:0] host_ms;
    rms_pkg::action_t           act;
    logic [rms_pkg::AMT_W-1:0]  amt;
  } motion_req_t;

  typedef struct {
    logic [1:0]                  robot_state;
    logic [rms_pkg::TIME_W-1:0]  end_time;
    logic [rms_pkg::ACT_W-1:0]   act;
    logic [rms_pkg::AMT_W-1:0]   amt;
    logic                        cmd_active;
    logic [rms_pkg::WHEEL_W-1:0] wheel;
    logic [rms_pkg::CNT_W-1:0]   level;
    logic                        overflow;
  } sup_status_t;

  class supervisor_scoreboard;
    sup_cfg_t                    regs;
    rms_pkg::robot_state_t       mode_st;
    logic [rms_pkg::TIME_W-1:0]  move_end;
    rms_pkg::action_t            cur_act;
    logic [rms_pkg::AMT_W-1:0]   cur_amt;
    logic                        cur_valid;
    logic [rms_pkg::WHEEL_W-1:0] cur_wheel;
    logic [rms_pkg::ENTRY_W-1:0] ring [RING_SLOTS];
    int unsigned                 head;
    int unsigned                 tail;
    sup_status_t                 status_q [$];
    int                          errors;

    function new(sup_cfg_t c);
      regs      = c;
      mode_st   = rms_pkg::RS_IDLE;
      move_end  = '0;
      cur_wheel = '0;
      head      = 0;
      tail      = 0;
      errors    = 0;
      drop_current();
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void drop_current();
      cur_act   = rms_pkg::ACT_STOP;
      cur_amt   = '0;
      cur_valid = 1'b0;
    endfunction

    function void pop_into_current(logic [rms_pkg::TIME_W-1:0] now);
      logic [rms_pkg::ENTRY_W-1:0] entry;
      logic [rms_pkg::SPEED_W-1:0] ratio;
      longint unsigned             span;
      if (head == tail) return;
      entry     = ring[head];
      head      = (head + 1) % RING_SLOTS;
      cur_act   = rms_pkg::action_t'(entry[rms_pkg::ENTRY_W-1:rms_pkg::AMT_W]);
      cur_amt   = entry[rms_pkg::AMT_W-1:0];
      cur_valid = 1'b1;
      move_end  = '0;
      if (cur_act == rms_pkg::ACT_STOP) begin
        mode_st = rms_pkg::RS_IDLE;
        return;
      end
      if (cur_act == rms_pkg::ACT_TURN) begin
        ratio     = regs.rot_rate;
        cur_wheel = regs.turn_whl;
      end else begin
        ratio     = regs.linear_speed;
        cur_wheel = regs.straight_whl;
      end
      if (ratio == '0) ratio = rms_pkg::SPEED_W'(1);
      span     = 64'(cur_amt);
      span     = (span * MS_PER_S) / ratio;
      mode_st  = rms_pkg::RS_MOVING;
      move_end = now + rms_pkg::TIME_W'(span);
    endfunction

    function void run_tick(logic [rms_pkg::TIME_W-1:0] now, logic [rms_pkg::DIST_W-1:0] range_cm,
                           logic [rms_pkg::TIME_W-1:0] host);
      logic [rms_pkg::TIME_W-1:0] silence;
      silence = now - host;
      if (range_cm <= regs.near_cm) begin
        mode_st  = rms_pkg::RS_EMERG;
        move_end = '0;
        return;
      end
      if (mode_st == rms_pkg::RS_EMERG) begin
        if (range_cm > regs.clear_cm) mode_st = rms_pkg::RS_IDLE;
        return;
      end
      if (mode_st == rms_pkg::RS_MOVING && silence > regs.host_timeout) begin
        mode_st  = rms_pkg::RS_IDLE;
        move_end = '0;
      end
      if (mode_st == rms_pkg::RS_MOVING && head != tail &&
          rms_pkg::action_t'(ring[head][rms_pkg::ENTRY_W-1:rms_pkg::AMT_W]) ==
          rms_pkg::ACT_STOP) begin
        head = (head + 1) % RING_SLOTS;
        drop_current();
        mode_st  = rms_pkg::RS_IDLE;
        move_end = '0;
        return;
      end
      if (mode_st == rms_pkg::RS_IDLE) pop_into_current(now);
      if (mode_st == rms_pkg::RS_MOVING && now >= move_end) begin
        mode_st  = rms_pkg::RS_IDLE;
        move_end = '0;
        drop_current();
      end
    endfunction

    function void note_request(motion_req_t r);
      sup_status_t s;
      logic        ovf;
      ovf = 1'b0;
      if (r.mode == rms_pkg::MODE_ENQ) begin
        if ((tail + 1) % RING_SLOTS == head) begin
          ovf = 1'b1;
        end else begin
          ring[tail] = {r.act, r.amt};
          tail = (tail + 1) % RING_SLOTS;
        end
      end else begin
        run_tick(r.now_ms, r.dist_cm, r.host_ms);
      end
      s.robot_state = mode_st;
      s.end_time    = move_end;
      s.act         = cur_act;
      s.amt         = cur_amt;
      s.cmd_active  = cur_valid;
      s.wheel       = cur_wheel;
      s.level       = rms_pkg::CNT_W'((tail + RING_SLOTS - head) % RING_SLOTS);
      s.overflow    = ovf;
      status_q.push_back(s);
    endfunction

    task report_mismatch(string what);
      if (errors < REPORT_CAP) $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_field(string name, logic [rms_pkg::TIME_W-1:0] got,
                     logic [rms_pkg::TIME_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_result(sup_status_t got);
      sup_status_t want;
      if (status_q.size() == 0) begin
        report_mismatch("status with no request pending");
        return;
      end
      want = status_q.pop_front();
      check_field("robot_state", rms_pkg::TIME_W'(got.robot_state),
                  rms_pkg::TIME_W'(want.robot_state));
      check_field("end_time_ms", got.end_time, want.end_time);
      check_field("active_action", rms_pkg::TIME_W'(got.act), rms_pkg::TIME_W'(want.act));
      check_field("active_amount", rms_pkg::TIME_W'(got.amt), rms_pkg::TIME_W'(want.amt));
      check_field("command_active", rms_pkg::TIME_W'(got.cmd_active),
                  rms_pkg::TIME_W'(want.cmd_active));
      check_field("wheel_speed", rms_pkg::TIME_W'(got.wheel), rms_pkg::TIME_W'(want.wheel));
      check_field("queue_count", rms_pkg::TIME_W'(got.level), rms_pkg::TIME_W'(want.level));
      check_field("queue_overflow", rms_pkg::TIME_W'(got.overflow),
                  rms_pkg::TIME_W'(want.overflow));
    endtask
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [rms_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [rms_pkg::CFG_DATA_W-1:0] cfg_wdata;

  rms_in_if  in_chan ();
  rms_out_if out_chan ();

  supervisor_scoreboard       sb;
  sup_cfg_t                   active_cfg;
  logic [rms_pkg::TIME_W-1:0] clock_ms;
  bit                         calm;
  bit                         stall_req;

  robot_motion_supervisor_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic motion_req_t make_enq(rms_pkg::action_t a, logic [rms_pkg::AMT_W-1:0] amt);
    motion_req_t r;
    r.mode    = rms_pkg::MODE_ENQ;
    r.now_ms  = $urandom;
    r.dist_cm = rms_pkg::DIST_W'($urandom);
    r.host_ms = $urandom;
    r.act     = a;
    r.amt     = amt;
    return r;
  endfunction

  function automatic motion_req_t make_tick(logic [rms_pkg::TIME_W-1:0] now,
                                            logic [rms_pkg::DIST_W-1:0] range_cm,
                                            logic [rms_pkg::TIME_W-1:0] host);
    motion_req_t r;
    r.mode    = rms_pkg::MODE_TICK;
    r.now_ms  = now;
    r.dist_cm = range_cm;
    r.host_ms = host;
    r.act     = rms_pkg::action_t'($urandom_range(3));
    r.amt     = rms_pkg::AMT_W'($urandom);
    return r;
  endfunction

  function automatic motion_req_t random_enqueue();
    rms_pkg::action_t          a;
    logic [rms_pkg::AMT_W-1:0] amt;
    int unsigned               pick;
    a = ($urandom_range(99) < 15) ? rms_pkg::ACT_STOP : rms_pkg::action_t'($urandom_range(3, 1));
    pick = $urandom_range(99);
    if (pick < 70) begin
      amt = rms_pkg::AMT_W'($urandom_range(300));
    end else if (pick < 90) begin
      amt = rms_pkg::AMT_W'($urandom_range(3000));
    end else if (pick < 98) begin
      amt = rms_pkg::AMT_W'($urandom);
    end else begin
      amt = $urandom_range(1) ? '1 : '0;
    end
    return make_enq(a, amt);
  endfunction

  function automatic motion_req_t random_tick();
    int unsigned                pick;
    logic [rms_pkg::TIME_W-1:0] host;
    logic [rms_pkg::DIST_W-1:0] range_cm;
    pick = $urandom_range(99);
    if (pick < 60) begin
      clock_ms += $urandom_range(300);
    end else if (pick < 85) begin
      clock_ms += $urandom_range(5000, 300);
    end else if (pick < 97) begin
      clock_ms += $urandom_range(400000);
    end else begin
      clock_ms = $urandom;
    end
    pick = $urandom_range(99);
    if (pick < 75) begin
      host = clock_ms - $urandom_range(active_cfg.host_timeout);
    end else if (pick < 90) begin
      host = clock_ms - active_cfg.host_timeout - 1 - $urandom_range(100);
    end else begin
      host = $urandom;
    end
    pick = $urandom_range(99);
    if (pick < 88) begin
      range_cm = (active_cfg.clear_cm == '1) ? '1 :
                 rms_pkg::DIST_W'($urandom_range(1023, active_cfg.clear_cm + 1));
    end else if (pick < 96) begin
      range_cm = rms_pkg::DIST_W'($urandom_range(active_cfg.near_cm));
    end else begin
      range_cm = rms_pkg::DIST_W'($urandom);
    end
    return make_tick(clock_ms, range_cm, host);
  endfunction

  function automatic sup_cfg_t random_cfg();
    sup_cfg_t c;
    c.host_timeout = $urandom_range(3000);
    c.linear_speed = rms_pkg::SPEED_W'($urandom_range(1023));
    c.rot_rate     = rms_pkg::SPEED_W'($urandom_range(1023));
    c.near_cm      = rms_pkg::DIST_W'($urandom_range(60));
    c.clear_cm     = rms_pkg::DIST_W'($urandom_range(120));
    c.straight_whl = rms_pkg::WHEEL_W'($urandom);
    c.turn_whl     = rms_pkg::WHEEL_W'($urandom);
    return c;
  endfunction

  task automatic send_request(input motion_req_t r);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid             <= 1'b1;
    in_chan.mode              <= r.mode;
    in_chan.now_ms            <= r.now_ms;
    in_chan.front_distance_cm <= r.dist_cm;
    in_chan.last_host_msg_ms  <= r.host_ms;
    in_chan.cmd_action        <= r.act;
    in_chan.cmd_amount        <= r.amt;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_request(r);
  endtask

  task automatic write_reg(input rms_pkg::cfg_idx_t idx,
                           input logic [rms_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic run_directed();
    send_request(make_enq(rms_pkg::ACT_FWD, 15'd0));
    send_request(make_enq(rms_pkg::ACT_FWD, 15'd40));
    send_request(make_enq(rms_pkg::ACT_STOP, 15'd0));
    send_request(make_enq(rms_pkg::ACT_TURN, '1));
    send_request(make_enq(rms_pkg::ACT_STOP, 15'd0));
    send_request(make_enq(rms_pkg::ACT_BACK, '1));
    repeat (RING_SLOTS - 7) send_request(random_enqueue());
    // queue is full now: drop this one
    send_request(make_enq(rms_pkg::ACT_TURN, '1));
    send_request(make_tick(32'd0, 10'd1023, 32'd0));
    send_request(make_tick(32'd100, 10'd500, 32'd100));
    send_request(make_tick(32'd200, 10'd500, 32'd200));
    send_request(make_tick(32'd300, 10'd500, 32'd300));
    send_request(make_tick(32'd5000, 10'd500, 32'd300));
    send_request(make_tick(32'd5100, 10'd20, 32'd5100));
    send_request(make_tick(32'd5200, 10'd40, 32'd5200));
    send_request(make_tick(32'd5300, 10'd41, 32'd5300));
    send_request(make_tick(32'hFFFF_FFF0, 10'd1023, 32'hFFFF_FFF0));
    clock_ms = 32'hFFFF_FFF0;
  endtask

  task automatic run_random(input int n_items);
    int sent;
    int unsigned pick;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        repeat (RING_SLOTS) begin
          send_request(random_enqueue());
          sent++;
        end
      end else if (pick < 40) begin
        send_request(random_enqueue());
        sent++;
      end else if (pick < 45) begin
        send_request(make_tick($urandom, rms_pkg::DIST_W'($urandom), $urandom));
        sent++;
      end else begin
        send_request(random_tick());
        sent++;
      end
    end
  endtask

  task automatic run_phase(input sup_cfg_t c, input int n_items, input bit squeeze);
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(rms_pkg::CFG_HOST_TIMEOUT, c.host_timeout);
    write_reg(rms_pkg::CFG_LINEAR_SPEED, rms_pkg::CFG_DATA_W'(c.linear_speed));
    write_reg(rms_pkg::CFG_ROT_RATE, rms_pkg::CFG_DATA_W'(c.rot_rate));
    write_reg(rms_pkg::CFG_NEAR_CM, rms_pkg::CFG_DATA_W'(c.near_cm));
    write_reg(rms_pkg::CFG_CLEAR_CM, rms_pkg::CFG_DATA_W'(c.clear_cm));
    write_reg(rms_pkg::CFG_STRAIGHT_WHL, rms_pkg::CFG_DATA_W'(c.straight_whl));
    write_reg(rms_pkg::CFG_TURN_WHL, rms_pkg::CFG_DATA_W'(c.turn_whl));
    cfg_we <= 1'b0;
    active_cfg = c;
    sb.regs    = c;
    if (squeeze) stall_req = 1'b1;
    run_random(n_items);
  endtask

  initial begin : result_sink
    int          hold_left;
    sup_status_t got;
    hold_left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got.robot_state = out_chan.robot_state;
        got.end_time    = out_chan.end_time_ms;
        got.act         = out_chan.active_action;
        got.amt         = out_chan.active_amount;
        got.cmd_active  = out_chan.command_active;
        got.wheel       = out_chan.wheel_speed;
        got.level       = out_chan.queue_count;
        got.overflow    = out_chan.queue_overflow;
        sb.check_result(got);
      end
      if (stall_req) begin
        hold_left = SQUEEZE_CYCLES;
        stall_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** robot_motion_supervisor_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    sup_cfg_t reset_cfg;
    reset_cfg = '{rms_pkg::RST_HOST_TIMEOUT, rms_pkg::RST_LINEAR_SPEED, rms_pkg::RST_ROT_RATE,
                  rms_pkg::RST_NEAR_CM, rms_pkg::RST_CLEAR_CM, rms_pkg::RST_STRAIGHT_WHL,
                  rms_pkg::RST_TURN_WHL};
    active_cfg = reset_cfg;
    sb         = new(reset_cfg);
    clock_ms   = '0;
    calm       = 1'b0;
    stall_req  = 1'b0;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    in_chan.valid             = 1'b0;
    in_chan.mode              = rms_pkg::MODE_TICK;
    in_chan.now_ms            = '0;
    in_chan.front_distance_cm = '0;
    in_chan.last_host_msg_ms  = '0;
    in_chan.cmd_action        = rms_pkg::ACT_STOP;
    in_chan.cmd_amount        = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(180);
    calm = 1'b1;
    run_phase('{32'd0, 10'd1, 10'd1, 10'd0, 10'd0, 8'd0, 8'd0}, 170, 1'b0);
    calm = 1'b0;
    run_phase('{32'hFFFF_FFFF, 10'd1023, 10'd1000, 10'd5, 10'd6, 8'hFF, 8'hFF}, 170, 1'b1);
    run_phase('{32'd500, 10'd0, 10'd0, 10'd1023, 10'd1023, 8'd85, 8'd170}, 25, 1'b0);
    run_phase('{32'd2000, 10'd0, 10'd0, 10'd30, 10'd60, 8'd85, 8'd170}, 170, 1'b0);
    run_phase(random_cfg(), 170, 1'b0);
    run_phase(random_cfg(), 170, 1'b1);
    run_phase(reset_cfg, 100, 1'b0);

    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** robot_motion_supervisor_unit: PASSED **");
    end else begin
      $display("** robot_motion_supervisor_unit: FAILED **");
    end
    $finish;
  end
endmodule
